@@ rtl/sra_pkg.sv @@
// Shared types and constants for the segment reorder and ack receiver.
package sra_pkg;

  localparam int SEQ_W  = 31;
  localparam int LEN_W  = 11;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIN     = 2'd2;

  typedef struct packed {
    logic [SEQ_W-1:0] segment_seq;
    logic [LEN_W-1:0] segment_length;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [SEQ_W-1:0]  out_seq;
    logic [LEN_W-1:0]  out_length;
    logic [SEQ_W-1:0]  ack_number;
    logic              last_result;
  } out_item_t;

  // One buffered out-of-order segment descriptor.
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
  } slot_t;

endpackage

@@ rtl/segment_reorder_ack_receiver.sv @@
// Segment reorder receiver with cumulative acks: sequencer, slot table and output register.
//
// Each segment descriptor is taken in S_IDLE, after which in_stall stays high until
// its last result has been loaded into the output register. A single compare/add unit
// and the one read port of the slot RAM set the pace. After accept and decode, the
// in-order deliver and ack and the final ack each load from a state of their own.
// A free-slot search walks the valid bits one slot a cycle (up to SLOTS slots). Every
// drain pass reads the table one slot at a time (S_SCAN, then S_CMP) and restarts
// from slot 0 after each match. A drained deliver is loaded from S_CMP once the output
// register is free. An in-order segment is delivered and acked and then drains the table;
// a zero-length segment (end of file) drains the table and ends with a FIN. A later
// segment is stored in a free slot, and an old or oversized one goes to the final ack.
// The result register lets the last result wait on out_stall while the next item is taken.
module segment_reorder_ack_receiver
  import sra_pkg::*;
#(
  parameter int SLOTS       = 16,
  parameter int MAX_PAYLOAD = 1456
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_PAYLOAD);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DLV,
    S_ACK0,
    S_SCAN,
    S_CMP,
    S_FREE,
    S_FINAL
  } state_t;

  state_t           state_r, state_nxt;
  logic [SEQ_W-1:0] expected_r, expected_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             slot_free;
  logic             load;
  out_item_t        load_item;
  logic             wr_en;
  slot_t            rd_slot;
  logic [$bits(slot_t)-1:0] rd_bits;
  logic [SEQ_W-1:0] probe;
  logic [LEN_W-1:0] addend;
  logic             cmp_eq, cmp_gt;
  logic [SEQ_W-1:0] cmp_sum;

  assign rd_slot = slot_t'(rd_bits);

  sra_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data ({seq_r, len_r}),
    .rd_addr (idx_r),
    .rd_data (rd_bits)
  );

  assign probe  = (state_r == S_CMP) ? rd_slot.seq : seq_r;
  assign addend = (state_r == S_CMP) ? rd_slot.len : len_r;

  sra_cmp u_cmp (
    .base   (expected_r),
    .probe  (probe),
    .addend (addend),
    .eq     (cmp_eq),
    .gt     (cmp_gt),
    .sum    (cmp_sum)
  );

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt    = state_r;
    expected_nxt = expected_r;
    valid_nxt    = valid_r;
    idx_nxt      = idx_r;
    seq_nxt      = seq_r;
    len_nxt      = len_r;
    load         = 1'b0;
    load_item    = '0;
    wr_en        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          seq_nxt   = in_data.segment_seq;
          len_nxt   = in_data.segment_length;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        idx_nxt = '0;
        if (len_r == '0) begin
          state_nxt = S_SCAN;
        end else if (len_r > MAX_LEN) begin
          state_nxt = S_FINAL;
        end else if (cmp_eq) begin
          state_nxt = S_DLV;
        end else if (cmp_gt) begin
          state_nxt = S_FREE;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_DLV: begin
        if (slot_free) begin
          load                = 1'b1;
          load_item.result_kind = KIND_DELIVER;
          load_item.out_seq     = seq_r;
          load_item.out_length  = len_r;
          state_nxt           = S_ACK0;
        end
      end
      S_ACK0: begin
        // expected still equals seq here, so the sum is seq + length
        if (slot_free) begin
          load                  = 1'b1;
          load_item.result_kind = KIND_ACK;
          load_item.ack_number  = cmp_sum;
          expected_nxt          = cmp_sum;
          idx_nxt               = '0;
          state_nxt             = S_SCAN;
        end
      end
      S_SCAN: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (valid_r[idx_r] && cmp_eq) begin
          if (slot_free) begin
            load                  = 1'b1;
            load_item.result_kind = KIND_DELIVER;
            load_item.out_seq     = rd_slot.seq;
            load_item.out_length  = rd_slot.len;
            expected_nxt          = cmp_sum;
            valid_nxt[idx_r]      = 1'b0;
            idx_nxt               = '0;
            state_nxt             = S_SCAN;
          end
        end else if (idx_r == LAST_IDX) begin
          state_nxt = S_FINAL;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_FREE: begin
        if (!valid_r[idx_r]) begin
          wr_en            = 1'b1;
          valid_nxt[idx_r] = 1'b1;
          state_nxt        = S_FINAL;
        end else if (idx_r == LAST_IDX) begin
          // table full: segment dropped
          state_nxt = S_FINAL;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_FINAL: begin
        if (slot_free) begin
          load                  = 1'b1;
          load_item.result_kind = (len_r == '0) ? KIND_FIN : KIND_ACK;
          load_item.ack_number  = expected_r;
          load_item.last_result = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = load_item;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      expected_r  <= '0;
      valid_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      expected_r  <= expected_nxt;
      valid_r     <= valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    seq_r      <= seq_nxt;
    len_r      <= len_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ rtl/sra_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/sra_cmp.sv @@
// Shared sequence unit: equality and greater-than compare plus byte-count add.
module sra_cmp
  import sra_pkg::*;
(
  input  logic [SEQ_W-1:0] base,
  input  logic [SEQ_W-1:0] probe,
  input  logic [LEN_W-1:0] addend,
  output logic             eq,
  output logic             gt,
  output logic [SEQ_W-1:0] sum
);

  assign eq  = (probe == base);
  assign gt  = (probe > base);
  // wraps modulo 2^31
  assign sum = base + SEQ_W'(addend);

endmodule

@@ rtl/sra_checker.sv @@
// Port-level checker for the segment reorder receiver, bound to the top level.
module sra_checker
  import sra_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // held item must not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // one item at a time: busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("item taken while previous one still in work");

  a_deliver_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_DELIVER |->
      out_data.ack_number == '0 && !out_data.last_result)
    else $error("deliver item malformed");

  a_ack_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == KIND_ACK || out_data.result_kind == KIND_FIN) |->
      out_data.out_seq == '0 && out_data.out_length == '0)
    else $error("ack item carries segment fields");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.result_kind == KIND_DELIVER || out_data.result_kind == KIND_ACK ||
                   out_data.result_kind == KIND_FIN))
    else $error("unknown result kind");

endmodule

bind segment_reorder_ack_receiver sra_checker u_sra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
